// ----- rtl/dbd_pkg.sv -----
// ---------------------------------------------------------------------------
// dbd_pkg
// Shared types, constants and helpers for the DLE byte destuffer.
// ---------------------------------------------------------------------------
package dbd_pkg;

    localparam int unsigned MAX_FRAME_LEN_DEF = 2048;

    localparam int unsigned CNT_W    = 12;
    localparam int unsigned POS_W    = 11;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STAT_W   = 2;
    localparam int unsigned APB_AW   = 5;
    localparam int unsigned APB_DW   = 32;
    localparam int unsigned OUT_DW   = 48;
    localparam int unsigned FIFO_DEPTH = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_MIN_LEN = 3'd0;
    localparam logic [2:0] REG_MAX_LEN = 3'd1;
    localparam logic [2:0] REG_ESC     = 3'd2;
    localparam logic [2:0] REG_SOH     = 3'd3;
    localparam logic [2:0] REG_STX     = 3'd4;
    localparam logic [2:0] REG_ETX     = 3'd5;
    localparam logic [2:0] REG_ISI     = 3'd6;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_LEN_ERR = 2'd1,
        ST_FMT_ERR = 2'd2
    } t_status;

    typedef struct packed {
        logic [CNT_W-1:0]  min_length;
        logic [CNT_W-1:0]  max_length;
        logic [BYTE_W-1:0] escape_code;
        logic [BYTE_W-1:0] soh_code;
        logic [BYTE_W-1:0] stx_code;
        logic [BYTE_W-1:0] etx_code;
        logic [BYTE_W-1:0] isi_code;
    } t_cfg;

    typedef struct packed {
        logic              last;
        logic [OUT_DW-1:0] data;
    } t_entry;

    typedef struct packed {
        logic [1:0] cnt;
        t_entry     e0;
        t_entry     e1;
    } t_push;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : CNT_W'(v + 1'b1);
    endfunction

    function automatic logic [POS_W-1:0] cap_pos(input logic [CNT_W-1:0] v);
        return (v > CNT_W'(POS_MAX)) ? POS_MAX : v[POS_W-1:0];
    endfunction

    // tdata: out_byte, frame_status, out_length, stx_index, etx_index
    function automatic logic [OUT_DW-1:0] pack_out(
        input logic [BYTE_W-1:0] b,
        input logic [STAT_W-1:0] st,
        input logic [CNT_W-1:0]  len,
        input logic [POS_W-1:0]  sp,
        input logic [POS_W-1:0]  ep
    );
        return {4'd0, ep, sp, len, st, b};
    endfunction

endpackage

// ----- rtl/dbd_cfg.sv -----
// ---------------------------------------------------------------------------
// dbd_cfg
// APB register bank holding lengths and control codes.
// ---------------------------------------------------------------------------
module dbd_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dbd_pkg::APB_AW-1:0]  paddr,
    input  logic [dbd_pkg::APB_DW-1:0]  pwdata,
    output logic [dbd_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output dbd_pkg::t_cfg               o_cfg
);

    dbd_pkg::t_cfg r_cfg;
    logic [2:0]    w_idx;
    logic          w_wr;

    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_length  <= 12'd4;
            r_cfg.max_length  <= 12'd2048;
            r_cfg.escape_code <= 8'd16;
            r_cfg.soh_code    <= 8'd1;
            r_cfg.stx_code    <= 8'd2;
            r_cfg.etx_code    <= 8'd3;
            r_cfg.isi_code    <= 8'd31;
        end else if (w_wr) begin
            case (w_idx)
                dbd_pkg::REG_MIN_LEN: r_cfg.min_length  <= pwdata[11:0];
                dbd_pkg::REG_MAX_LEN: r_cfg.max_length  <= pwdata[11:0];
                dbd_pkg::REG_ESC:     r_cfg.escape_code <= pwdata[7:0];
                dbd_pkg::REG_SOH:     r_cfg.soh_code    <= pwdata[7:0];
                dbd_pkg::REG_STX:     r_cfg.stx_code    <= pwdata[7:0];
                dbd_pkg::REG_ETX:     r_cfg.etx_code    <= pwdata[7:0];
                dbd_pkg::REG_ISI:     r_cfg.isi_code    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            dbd_pkg::REG_MIN_LEN: prdata = {20'd0, r_cfg.min_length};
            dbd_pkg::REG_MAX_LEN: prdata = {20'd0, r_cfg.max_length};
            dbd_pkg::REG_ESC:     prdata = {24'd0, r_cfg.escape_code};
            dbd_pkg::REG_SOH:     prdata = {24'd0, r_cfg.soh_code};
            dbd_pkg::REG_STX:     prdata = {24'd0, r_cfg.stx_code};
            dbd_pkg::REG_ETX:     prdata = {24'd0, r_cfg.etx_code};
            dbd_pkg::REG_ISI:     prdata = {24'd0, r_cfg.isi_code};
            default:              prdata = '0;
        endcase
    end

endmodule

// ----- rtl/dbd_core.sv -----
// ---------------------------------------------------------------------------
// dbd_core
// Input register, DLE lookahead state and per-frame counters; builds up to
// two output words per input word.
// ---------------------------------------------------------------------------
module dbd_core #(
    parameter int unsigned MAX_FRAME_LEN = dbd_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dbd_pkg::t_cfg               i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [dbd_pkg::BYTE_W-1:0]  i_byte,
    input  logic                        i_last,
    input  logic                        i_room2,
    output dbd_pkg::t_push              o_push
);

    logic                       r_in_valid;
    logic [dbd_pkg::BYTE_W-1:0] r_in_byte;
    logic                       r_in_last;

    logic                       r_esc_pend, n_esc_pend;
    logic [dbd_pkg::CNT_W-1:0]  r_raw, n_raw;
    logic [dbd_pkg::CNT_W-1:0]  r_kept, n_kept;
    logic [dbd_pkg::POS_W-1:0]  r_stx_pos, n_stx_pos;
    logic [dbd_pkg::POS_W-1:0]  r_etx_pos, n_etx_pos;
    logic                       r_stx_found, n_stx_found;
    logic                       r_etx_found, n_etx_found;

    logic                       w_adv;
    logic                       w_is_stx, w_is_etx, w_drop, w_emit_dle, w_emit_b;
    logic [dbd_pkg::CNT_W-1:0]  w_raw, w_kept1, w_kept2;
    logic [dbd_pkg::POS_W-1:0]  w_stx_pos, w_etx_pos;
    logic                       w_stx_found, w_etx_found;
    dbd_pkg::t_status           w_status;
    dbd_pkg::t_entry            w_dle_e, w_b_e;

    assign w_adv   = r_in_valid && i_room2;
    assign o_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
            r_in_last <= i_last;
        end
    end

    always_comb begin
        w_raw    = dbd_pkg::sat_inc(r_raw);
        w_is_stx = r_esc_pend && (r_in_byte == i_cfg.stx_code);
        w_is_etx = r_esc_pend && (r_in_byte == i_cfg.etx_code);
        w_drop   = r_esc_pend && ((r_in_byte == i_cfg.soh_code) || w_is_stx ||
                   w_is_etx || (r_in_byte == i_cfg.isi_code));
        w_emit_dle = r_esc_pend && !w_drop;
        w_emit_b   = !((r_in_byte == i_cfg.escape_code) && !r_in_last);

        w_stx_pos   = w_is_stx ? dbd_pkg::cap_pos(r_kept) : r_stx_pos;
        w_etx_pos   = w_is_etx ? dbd_pkg::cap_pos(r_kept) : r_etx_pos;
        w_stx_found = r_stx_found || w_is_stx;
        w_etx_found = r_etx_found || w_is_etx;

        w_kept1 = w_emit_dle ? dbd_pkg::sat_inc(r_kept) : r_kept;
        w_kept2 = w_emit_b   ? dbd_pkg::sat_inc(w_kept1) : w_kept1;

        if ((w_raw < i_cfg.min_length) || (w_raw > i_cfg.max_length) ||
            ({20'd0, w_raw} > 32'(MAX_FRAME_LEN))) begin
            w_status = dbd_pkg::ST_LEN_ERR;
        end else if (!w_stx_found || !w_etx_found || (w_stx_pos >= w_etx_pos)) begin
            w_status = dbd_pkg::ST_FMT_ERR;
        end else begin
            w_status = dbd_pkg::ST_OK;
        end

        w_dle_e.last = 1'b0;
        w_dle_e.data = dbd_pkg::pack_out(i_cfg.escape_code, '0, '0, '0, '0);
        w_b_e.last   = r_in_last;
        if (r_in_last) begin
            w_b_e.data = dbd_pkg::pack_out(r_in_byte, w_status, w_kept2,
                                           w_stx_pos, w_etx_pos);
        end else begin
            w_b_e.data = dbd_pkg::pack_out(r_in_byte, '0, '0, '0, '0);
        end

        o_push.e1 = w_b_e;
        if (w_emit_dle) begin
            o_push.e0  = w_dle_e;
            o_push.cnt = w_emit_b ? 2'd2 : 2'd1;
        end else begin
            o_push.e0  = w_b_e;
            o_push.cnt = w_emit_b ? 2'd1 : 2'd0;
        end
        if (!w_adv) begin
            o_push.cnt = 2'd0;
        end

        n_esc_pend  = r_esc_pend;
        n_raw       = r_raw;
        n_kept      = r_kept;
        n_stx_pos   = r_stx_pos;
        n_etx_pos   = r_etx_pos;
        n_stx_found = r_stx_found;
        n_etx_found = r_etx_found;
        if (w_adv) begin
            if (r_in_last) begin
                n_esc_pend  = 1'b0;
                n_raw       = '0;
                n_kept      = '0;
                n_stx_pos   = '0;
                n_etx_pos   = '0;
                n_stx_found = 1'b0;
                n_etx_found = 1'b0;
            end else begin
                n_esc_pend  = !w_emit_b;
                n_raw       = w_raw;
                n_kept      = w_kept2;
                n_stx_pos   = w_stx_pos;
                n_etx_pos   = w_etx_pos;
                n_stx_found = w_stx_found;
                n_etx_found = w_etx_found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_pend  <= 1'b0;
            r_raw       <= '0;
            r_kept      <= '0;
            r_stx_pos   <= '0;
            r_etx_pos   <= '0;
            r_stx_found <= 1'b0;
            r_etx_found <= 1'b0;
        end else begin
            r_esc_pend  <= n_esc_pend;
            r_raw       <= n_raw;
            r_kept      <= n_kept;
            r_stx_pos   <= n_stx_pos;
            r_etx_pos   <= n_etx_pos;
            r_stx_found <= n_stx_found;
            r_etx_found <= n_etx_found;
        end
    end

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> (r_raw == '0) && (r_kept == '0) && !r_esc_pend)
        else $error("frame state not cleared after last word");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |-> (o_push.cnt != 2'd0))
        else $error("last word produced no output");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_stx_pos} <= r_kept) && ({1'b0, r_etx_pos} <= r_kept))
        else $error("recorded position beyond output count");

endmodule

// ----- rtl/dbd_ofifo.sv -----
// ---------------------------------------------------------------------------
// dbd_ofifo
// Small output queue; takes up to two words per cycle, gives one while i_ready is high.
// ---------------------------------------------------------------------------
module dbd_ofifo #(
    parameter int unsigned DEPTH = dbd_pkg::FIFO_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dbd_pkg::t_push              i_push,
    output logic                        o_room2,
    output logic                        o_valid,
    input  logic                        i_ready,
    output dbd_pkg::t_entry             o_entry
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    dbd_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]   r_wp, n_wp;
    logic [AW-1:0]   r_rp, n_rp;
    logic [CW-1:0]   r_count, n_count;
    logic            w_pop;

    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rp];
    assign o_room2 = (r_count <= CW'(DEPTH - 2));
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wp    = AW'(r_wp + AW'(i_push.cnt));
        n_rp    = w_pop ? AW'(r_rp + 1'b1) : r_rp;
        n_count = CW'(r_count + CW'(i_push.cnt) - CW'(w_pop));
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.e0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[AW'(r_wp + 1'b1)] <= i_push.e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

// ----- rtl/dle_byte_destuffer.sv -----
// Datapath: bytes are registered, then queued; a DLE waits for the next
//   byte and leaves with it, or is dropped before SOH, STX, ETX or ISI.
// Throughput: one input word per cycle while the 4-entry output queue has
//   room for two; a word after a held DLE may yield two output words.
// Reset: synchronous, active low; clears frame state, queue and registers
//   to their default codes and lengths.
// ---------------------------------------------------------------------------
// dle_byte_destuffer
// DLE destuffer with STX/ETX position capture and frame status.
// ---------------------------------------------------------------------------
module dle_byte_destuffer #(
    parameter int unsigned MAX_FRAME_LEN = dbd_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] data_byte
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [7:0] out_byte, [9:8] frame_status, [21:10] out_length,
    // [32:22] stx_index, [43:33] etx_index, [47:44] zero
    output logic [dbd_pkg::OUT_DW-1:0]  m_axis_tdata,
    output logic                        m_axis_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dbd_pkg::APB_AW-1:0]  paddr,
    input  logic [dbd_pkg::APB_DW-1:0]  pwdata,
    output logic [dbd_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    dbd_pkg::t_cfg   w_cfg;
    dbd_pkg::t_push  w_push;
    dbd_pkg::t_entry w_entry;
    logic            w_room2;

    dbd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dbd_core #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_room2 (w_room2),
        .o_push  (w_push)
    );

    dbd_ofifo #(
        .DEPTH (dbd_pkg::FIFO_DEPTH)
    ) u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room2 (w_room2),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_entry (w_entry)
    );

    assign m_axis_tdata = w_entry.data;
    assign m_axis_tlast = w_entry.last;

endmodule
